@@ sv/bisc_pkg.sv @@
// Package for the bitmap intersect support count unit.
// Field widths, the support saturation limit, the result struct and the
// byte population count. No dependencies.
package bisc_pkg;

    localparam int unsigned WORD_W           = 32;
    localparam int unsigned SUPPORT_W        = 21;
    localparam int unsigned MAX_TRANSACTIONS = 1048576;
    localparam int unsigned SUPPORT_MASK     = (1 << SUPPORT_W) - 1;

    // Saturation limit: MAX_TRANSACTIONS, or all ones when it does not fit
    localparam int unsigned SUPPORT_CAP_INT  =
        (MAX_TRANSACTIONS > SUPPORT_MASK) ? SUPPORT_MASK : MAX_TRANSACTIONS;

    localparam int unsigned BYTE_CNT_W = 4;   // 0..8
    localparam int unsigned WORD_CNT_W = 6;   // 0..32
    localparam int unsigned SUM_W      = SUPPORT_W + 1;

    localparam logic [SUPPORT_W-1:0] SUPPORT_CAP = SUPPORT_CAP_INT[SUPPORT_W-1:0];

    localparam int unsigned S_TDATA_W = 64;   // word_a, word_b
    localparam int unsigned M_TDATA_W = 56;   // joined_word, support_total, pad

    typedef struct packed {
        logic [WORD_W-1:0]    joined_word;
        logic [SUPPORT_W-1:0] support_total;
        logic                 frequent;
    } join_result_t;

    function automatic logic [BYTE_CNT_W-1:0] byte_ones(input logic [7:0] b);
        logic [BYTE_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {{(BYTE_CNT_W-1){1'b0}}, b[i]};
        end
        return n;
    endfunction

endpackage

@@ sv/bisc_join_count.sv @@
// Combinational join and count: AND of two bitmap words, population count,
// saturating add onto the running support and the minimum-support compare.
// Depends on bisc_pkg.
module bisc_join_count (
    input  logic [bisc_pkg::WORD_W-1:0]    word_a,
    input  logic [bisc_pkg::WORD_W-1:0]    word_b,
    input  logic                           last_word,
    input  logic [bisc_pkg::SUPPORT_W-1:0] support_accum,
    input  logic [bisc_pkg::SUPPORT_W-1:0] min_support,
    output bisc_pkg::join_result_t         result
);
    import bisc_pkg::*;

    logic [WORD_W-1:0]     joined;
    logic [WORD_CNT_W-1:0] word_ones;
    logic [SUM_W-1:0]      sum;
    logic [SUPPORT_W-1:0]  sum_sat;

    always_comb begin
        joined    = word_a & word_b;
        // Count each byte, then add the four byte counts
        word_ones = {2'b00, byte_ones(joined[7:0])}
                  + {2'b00, byte_ones(joined[15:8])}
                  + {2'b00, byte_ones(joined[23:16])}
                  + {2'b00, byte_ones(joined[31:24])};
        sum       = {1'b0, support_accum}
                  + {{(SUM_W-WORD_CNT_W){1'b0}}, word_ones};
        // Clamp at the saturation limit
        if (sum > {1'b0, SUPPORT_CAP}) begin
            sum_sat = SUPPORT_CAP;
        end else begin
            sum_sat = sum[SUPPORT_W-1:0];
        end
        result.joined_word   = joined;
        result.support_total = sum_sat;
        result.frequent      = last_word && (sum_sat >= min_support);
    end

endmodule

@@ sv/bitmap_intersect_support_count_unit.sv @@
// Top level of the bitmap intersect support count unit.
// Holds the input register, the running support count and the result register.
// Depends on bisc_pkg and bisc_join_count.
//
// Each input beat carries one 32-bit word from each of two transaction bitmaps
// (word_a in s_tdata[31:0], word_b in s_tdata[63:32]) and s_tlast marks the final
// word pair. Every beat gives exactly one result beat: the AND of the two words,
// the running support count including this word (saturating at
// MAX_TRANSACTIONS), tlast copied from the input, and on the final beat a
// frequent flag in m_tuser that is set when the total is at least min_support.
// The count clears after the final beat. An accepted beat is held in the input
// register, then its result in the result register; the unit accepts one beat
// every cycle while m_tready does not stall the result register, as the popcount
// and accumulate between the two registers are combinational. Write min_support
// through cfg_wr_en/cfg_wr_data only while no beat is in flight.
module bitmap_intersect_support_count_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: min_support
    input  logic                                cfg_wr_en,
    input  logic [bisc_pkg::SUPPORT_W-1:0]      cfg_wr_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bisc_pkg::S_TDATA_W-1:0]      s_tdata,   // [31:0] word_a, [63:32] word_b
    input  logic                                s_tlast,   // last_word
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bisc_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] joined_word,
                                                           // [52:32] support_total, [55:53] zero
    output logic                                m_tlast,   // is_final
    output logic                                m_tuser    // frequent
);
    import bisc_pkg::*;

    // Input register stage
    logic                 in_valid_reg, in_valid_next;
    logic [WORD_W-1:0]    in_word_a_reg, in_word_b_reg;
    logic                 in_last_reg;

    // Result register stage
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]    out_joined_reg;
    logic [SUPPORT_W-1:0] out_total_reg;
    logic                 out_last_reg;
    logic                 out_freq_reg;

    // Running count and configuration
    logic [SUPPORT_W-1:0] support_accum_reg, support_accum_next;
    logic [SUPPORT_W-1:0] min_support_reg;

    logic                 s_accept;
    logic                 advance;
    join_result_t         result;

    // Advance the input stage when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    bisc_join_count u_join_count (
        .word_a        (in_word_a_reg),
        .word_b        (in_word_b_reg),
        .last_word     (in_last_reg),
        .support_accum (support_accum_reg),
        .min_support   (min_support_reg),
        .result        (result)
    );

    always_comb begin
        in_valid_next      = s_accept || (in_valid_reg && !advance);
        out_valid_next     = advance || (out_valid_reg && !m_tready);
        support_accum_next = support_accum_reg;
        if (advance) begin
            // Clear the count after the final word pair
            support_accum_next = in_last_reg ? '0 : result.support_total;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            support_accum_reg <= '0;
            min_support_reg   <= '0;
        end else begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            support_accum_reg <= support_accum_next;
            if (cfg_wr_en) begin
                min_support_reg <= cfg_wr_data;
            end
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_word_a_reg <= s_tdata[WORD_W-1:0];
            in_word_b_reg <= s_tdata[2*WORD_W-1:WORD_W];
            in_last_reg   <= s_tlast;
        end
        if (advance) begin
            out_joined_reg <= result.joined_word;
            out_total_reg  <= result.support_total;
            out_last_reg   <= in_last_reg;
            out_freq_reg   <= result.frequent;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-WORD_W-SUPPORT_W){1'b0}}, out_total_reg, out_joined_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_freq_reg;

endmodule
